/* rtl/core/pes_pkg.sv */
// Shared constants, types and helpers for the prefix expression stack evaluator.
`default_nettype none

package pes_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int STATUS_W    = 3;

  localparam logic [7:0] CH_ADD  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB  = 8'h2D;  // '-'
  localparam logic [7:0] CH_MUL  = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV  = 8'h2F;  // '/'
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_ADD) || (c == CH_SUB) || (c == CH_MUL) || (c == CH_DIV);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pes_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pes_div.sv */
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
`default_nettype none

module pes_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pes_pkg::div_req_t req,
  output pes_pkg::div_rsp_t      rsp
);

  localparam int W = pes_pkg::DATA_W;

  logic [W-1:0]         rem;
  logic [W-1:0]         quo;
  logic [W-1:0]         den;
  logic                 neg;
  logic                 busy;
  logic                 done;
  logic [$clog2(W)-1:0] cnt;

  logic [W:0]   shifted;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;

  assign mag_a   = req.dividend[W-1] ? (W'(0) - req.dividend) : req.dividend;
  assign mag_b   = req.divisor[W-1]  ? (W'(0) - req.divisor)  : req.divisor;
  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, den};
  assign ge      = !diff[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= mag_a;
      den <= mag_b;
      neg <= req.dividend[W-1] ^ req.divisor[W-1];
      cnt <= '1;
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  // {done, quotient}
  assign rsp = {done, (neg ? (W'(0) - quo) : quo)};

endmodule

`default_nettype wire

/* rtl/core/prefix_expression_stack_evaluator.sv */
// Steps: a push or an error character is handled in S_IDLE alone; '+', '-' and '*' read
//   the right operand from memory and execute in S_EXEC; '/' with a nonzero divisor then
//   waits in S_DIV for the bit-serial divider. A character is taken only in S_IDLE,
//   so the divider sets the worst case; a final character also loads the output register.
// Reset (rst, synchronous, active high) empties the stack, clears the error and drops any
//   pending result; stack memory contents are not cleared and need no clearing pass.
`default_nettype none

module prefix_expression_stack_evaluator (
  input  wire logic        clk,
  input  wire logic        rst,
  // input characters
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] ch
  input  wire logic        s_tlast,   // last character of the expression
  // results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] value
  output logic [2:0]       m_tuser    // [2:0] status
);

  localparam int W  = pes_pkg::DATA_W;
  localparam int AW = pes_pkg::ADDR_W;
  localparam int CW = pes_pkg::CNT_W;

  // One-hot sequencer.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // ready for a character
    S_EXEC = 4'b0010,  // second operand back from memory
    S_DIV  = 4'b0100,  // waiting on the divider
    S_FIN  = 4'b1000   // final character: hand result to output register
  } state_t;

  state_t                           state, state_next;
  logic [CW-1:0]                    count, count_next;
  logic [pes_pkg::STATUS_W-1:0]     err, err_next;
  logic [W-1:0]                     top, top_next;   // top of stack lives here
  logic [7:0]                       op, op_next;
  logic                             last_q, last_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [W-1:0]  ram_rdata;

  pes_pkg::div_req_t div_req;
  pes_pkg::div_rsp_t div_rsp;

  logic out_load;
  logic done_state_is_fin;

  // The memory holds entries 0 .. count-2; entry count-1 is kept in 'top', so an
  // operator needs a single memory read for its right operand. A push spills the
  // old top to memory. Reads and writes never fall in the same cycle, so no
  // forwarding is needed.
  pes_ram #(
    .WIDTH (W),
    .DEPTH (pes_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pes_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_tready  = (state == S_IDLE);
  assign ram_waddr = AW'(count - CW'(1));
  assign ram_raddr = AW'(count - CW'(2));
  assign ram_wdata = top;

  // Where a character goes once its stack work is done.
  assign done_state_is_fin = last_q;

  always_comb begin
    state_next       = state;
    count_next       = count;
    err_next         = err;
    top_next         = top;
    op_next          = op;
    last_next        = last_q;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = top;        // left operand
    div_req.divisor  = ram_rdata;  // right operand
    out_load         = 1'b0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op_next    = s_tdata;
          last_next  = s_tlast;
          state_next = s_tlast ? S_FIN : S_IDLE;
          if (err != pes_pkg::ST_OK) begin
            // expression already failed: ignore the rest of it
          end else if (pes_pkg::is_op(s_tdata)) begin
            if (count < CW'(2)) begin
              err_next   = pes_pkg::ST_UNDERFLOW;
              count_next = '0;
            end else begin
              ram_re     = 1'b1;
              state_next = S_EXEC;
            end
          end else if (count >= CW'(pes_pkg::STACK_DEPTH)) begin
            err_next   = pes_pkg::ST_OVERFLOW;
            count_next = '0;
          end else begin
            ram_we     = (count != '0);
            top_next   = {{(W-8){1'b0}}, s_tdata} - {{(W-8){1'b0}}, pes_pkg::CH_ZERO};
            count_next = count + CW'(1);
          end
        end
      end

      S_EXEC: begin
        state_next = done_state_is_fin ? S_FIN : S_IDLE;
        case (op)
          pes_pkg::CH_ADD: begin
            top_next   = top + ram_rdata;
            count_next = count - CW'(1);
          end
          pes_pkg::CH_SUB: begin
            top_next   = top - ram_rdata;
            count_next = count - CW'(1);
          end
          pes_pkg::CH_MUL: begin
            top_next   = top * ram_rdata;  // low 32 bits, wraps
            count_next = count - CW'(1);
          end
          pes_pkg::CH_DIV: begin
            if (ram_rdata == '0) begin
              err_next   = pes_pkg::ST_DIVZERO;
              count_next = '0;
            end else begin
              div_req.start = 1'b1;
              state_next    = S_DIV;
            end
          end
          default: begin
          end
        endcase
      end

      S_DIV: begin
        if (div_rsp.done) begin
          top_next   = div_rsp.quotient;
          count_next = count - CW'(1);
          state_next = done_state_is_fin ? S_FIN : S_IDLE;
        end
      end

      S_FIN: begin
        // Wait here only if the previous result has not been taken yet.
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          count_next = '0;
          err_next   = pes_pkg::ST_OK;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      err    <= pes_pkg::ST_OK;
      last_q <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      err    <= err_next;
      last_q <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    op  <= op_next;
  end

  // Output register: decouples result delivery from the character side.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (err != pes_pkg::ST_OK) begin
        m_tdata <= '0;
        m_tuser <= err;
      end else if (count == '0) begin
        m_tdata <= '0;
        m_tuser <= pes_pkg::ST_EMPTY;
      end else begin
        m_tdata <= top;
        m_tuser <= pes_pkg::ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pes_chk.sv */
// Port-level checker for the prefix expression stack evaluator, with its bind.
`default_nettype none

module pes_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result transaction changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output not empty or input not ready after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= pes_pkg::ST_EMPTY)
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != pes_pkg::ST_OK |-> m_tdata == '0)
    else $error("nonzero value reported with an error status");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !(s_tvalid && s_tready) && s_tready |=> !m_tvalid)
    else $error("result appeared with no character pending");

endmodule

bind prefix_expression_stack_evaluator pes_chk u_pes_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

/* verif/prefix_expression_stack_evaluator_tb.sv */
// Testbench for the prefix expression stack evaluator: random and directed streams, self-checked.
`timescale 1ns / 100ps

module prefix_expression_stack_evaluator_tb;

  localparam int unsigned CHAR_BUDGET = 1050;       // characters to send before stopping
  localparam int unsigned QUIET_TAIL  = 150;        // last characters sent with no idling
  localparam int unsigned TIMEOUT_NS  = 2_000_000;  // simulation time limit, in ns

  // Tracks the operand stack and the sticky error; queues up one
  // (value, status) pair per expression and checks the DUT against it.
  class expr_scoreboard;
    logic [pes_pkg::DATA_W-1:0] operands [pes_pkg::STACK_DEPTH];
    int unsigned                depth;
    logic [2:0]                 err;
    logic [pes_pkg::DATA_W-1:0] value_q [$];
    logic [2:0]                 status_q [$];
    int unsigned                failures;
    int unsigned                checked;
    int unsigned                by_status [8];

    function new();
      depth    = 0;
      err      = pes_pkg::ST_OK;
      failures = 0;
      checked  = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function int unsigned pending();
      return value_q.size();
    endfunction

    // One accepted input transaction.
    function void note_input(logic [7:0] ch, logic last);
      logic [pes_pkg::DATA_W-1:0] lhs, rhs, res, qmag;
      logic                       is_operator;
      is_operator = (ch == pes_pkg::CH_ADD) || (ch == pes_pkg::CH_SUB) ||
                    (ch == pes_pkg::CH_MUL) || (ch == pes_pkg::CH_DIV);
      if (err == pes_pkg::ST_OK) begin
        if (is_operator) begin
          if (depth < 2) begin
            err   = pes_pkg::ST_UNDERFLOW;
            depth = 0;
          end else begin
            lhs = operands[depth-1];  // top is the left operand
            rhs = operands[depth-2];
            if (ch == pes_pkg::CH_DIV && rhs == '0) begin
              err   = pes_pkg::ST_DIVZERO;
              depth = 0;
            end else begin
              case (ch)
                pes_pkg::CH_ADD: res = lhs + rhs;
                pes_pkg::CH_SUB: res = lhs - rhs;
                pes_pkg::CH_MUL: res = lhs * rhs;
                default: begin
                  // truncate toward zero on magnitudes; MIN / -1 wraps back to MIN
                  qmag = (lhs[31] ? -lhs : lhs) / (rhs[31] ? -rhs : rhs);
                  res  = (lhs[31] ^ rhs[31]) ? -qmag : qmag;
                end
              endcase
              depth = depth - 1;
              operands[depth-1] = res;
            end
          end
        end else if (depth >= pes_pkg::STACK_DEPTH) begin
          err   = pes_pkg::ST_OVERFLOW;
          depth = 0;
        end else begin
          operands[depth] = {24'd0, ch} - {24'd0, pes_pkg::CH_ZERO};
          depth = depth + 1;
        end
      end
      if (last) begin
        if (err != pes_pkg::ST_OK) begin
          value_q.push_back('0);
          status_q.push_back(err);
        end else if (depth == 0) begin
          value_q.push_back('0);
          status_q.push_back(pes_pkg::ST_EMPTY);
        end else begin
          value_q.push_back(operands[depth-1]);
          status_q.push_back(pes_pkg::ST_OK);
        end
        by_status[status_q[$]]++;
        depth = 0;
        err   = pes_pkg::ST_OK;
      end
    endfunction

    // One accepted result transaction.
    function void check_result(logic [pes_pkg::DATA_W-1:0] value, logic [2:0] status);
      logic [pes_pkg::DATA_W-1:0] exp_value;
      logic [2:0]                 exp_status;
      if (value_q.size() == 0) begin
        failures++;
        $display("%0t: result with nothing expected: value=%0d status=%0d",
                 $time, $signed(value), status);
        return;
      end
      exp_value  = value_q.pop_front();
      exp_status = status_q.pop_front();
      checked++;
      if (value !== exp_value) begin
        failures++;
        $display("%0t: value mismatch: expected %0d, actual %0d",
                 $time, $signed(exp_value), $signed(value));
      end
      if (status !== exp_status) begin
        failures++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp_status, status);
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;   // [7:0] ch
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [31:0] value
  logic [2:0]  m_tuser;           // [2:0] status

  expr_scoreboard sb = new();

  logic [7:0]  expr_q [$];        // characters of one expression, evaluation order
  int unsigned sent_count = 0;
  int unsigned expr_count = 0;
  bit          quiet      = 1'b0; // no idling on either side
  bit          calm       = 1'b0; // per-expression stretch with no idling
  int          stall_left = 0;

  prefix_expression_stack_evaluator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Both handshakes are sampled at the same edge; inputs first so an expectation
  // always exists before its result could show up.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  // Result side backpressure: random stall bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Drive one character and hold it until the transaction completes.
  task automatic send_char(input logic [7:0] ch, input logic last);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sent_count++;
  endtask

  task automatic send_expression();
    foreach (expr_q[i]) send_char(expr_q[i], i == expr_q.size() - 1);
    expr_count++;
  endtask

  // Hold off the sender until every pending result has been returned.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_operand();
    logic [7:0] c;
    if ($urandom_range(0, 2) != 0) begin
      c = pes_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    end else begin
      do c = 8'($urandom_range(0, 255));
      while (c == pes_pkg::CH_ADD || c == pes_pkg::CH_SUB ||
             c == pes_pkg::CH_MUL || c == pes_pkg::CH_DIV);
    end
    return c;
  endfunction

  function automatic logic [7:0] rand_operator(bit allow_div);
    case ($urandom_range(0, allow_div ? 3 : 2))
      0:       return pes_pkg::CH_ADD;
      1:       return pes_pkg::CH_SUB;
      2:       return pes_pkg::CH_MUL;
      default: return pes_pkg::CH_DIV;
    endcase
  endfunction

  // Well-formed expression: n operands, leaving 'keep' entries on the stack.
  // stack_first pushes every operand before the first operator (deep stacks).
  task automatic build_expression(input int n, input int keep, input bit stack_first,
                                  input bit allow_div);
    int remaining;
    int depth;
    remaining = n;
    depth     = 0;
    expr_q.delete();
    while (remaining > 0 || depth > keep) begin
      if (remaining > 0 && (depth < 2 || stack_first || $urandom_range(0, 1))) begin
        expr_q.push_back(rand_operand());
        remaining--;
        depth++;
      end else begin
        expr_q.push_back(rand_operator(allow_div));
        depth--;
      end
    end
  endtask

  initial begin
    int kind;
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes and add
    expr_q = {8'hFF, 8'h00, pes_pkg::CH_ADD};
    send_expression();
    // divide truncating toward zero (-7 / 2), then subtract and multiply
    expr_q = {8'h32, 8'h29, pes_pkg::CH_DIV, 8'h39, pes_pkg::CH_SUB, 8'h33,
              pes_pkg::CH_MUL};
    send_expression();
    // underflow on the first character; the rest of the expression is ignored
    expr_q = {pes_pkg::CH_MUL, 8'h35, 8'h33};
    send_expression();
    // divide by zero
    expr_q = {pes_pkg::CH_ZERO, 8'h35, pes_pkg::CH_DIV};
    send_expression();
    // most negative value divided by minus one: -1 = 0 - 1, MIN = 128^4 * 8
    expr_q = {8'h31, pes_pkg::CH_ZERO, pes_pkg::CH_SUB, 8'hB0, 8'hB0,
              pes_pkg::CH_MUL, 8'hB0, pes_pkg::CH_MUL, 8'hB0, pes_pkg::CH_MUL,
              8'h38, pes_pkg::CH_MUL, pes_pkg::CH_DIV};
    send_expression();
    drain();

    // Random: mostly well-formed expressions, some deep stacks, broken ones and noise
    while (sent_count < CHAR_BUDGET) begin
      quiet = (sent_count + QUIET_TAIL >= CHAR_BUDGET);
      calm  = ($urandom_range(0, 4) == 0);
      kind  = $urandom_range(0, 99);
      if (kind < 3) begin
        // 62..66 operands pushed first: full stack and overflow
        build_expression($urandom_range(62, 66), 1, 1'b1, $urandom_range(0, 1));
      end else if (kind < 15) begin
        expr_q.delete();
        repeat ($urandom_range(1, 8)) begin
          expr_q.push_back($urandom_range(0, 1) ? rand_operator(1'b1)
                                                : 8'($urandom_range(0, 255)));
        end
      end else if (kind < 27) begin
        build_expression($urandom_range(1, 8), 1, 1'b0, 1'b1);
        pick = $urandom_range(0, expr_q.size() - 1);
        case ($urandom_range(0, 2))
          0: expr_q[pick] = rand_operator(1'b1);
          1: expr_q[pick] = rand_operand();
          default: if (expr_q.size() > 1) expr_q.delete(pick);
        endcase
      end else begin
        pick = $urandom_range(1, 8);
        build_expression(pick, ($urandom_range(0, 9) == 0) ? $urandom_range(1, pick) : 1,
                         1'b0, 1'b1);
      end
      send_expression();
      if (!quiet && $urandom_range(0, 19) == 0) drain();
    end
    s_tvalid <= 1'b0;
    calm     = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d characters in %0d expressions; %0d results checked.",
             sent_count, expr_count, sb.checked);
    $display("Statuses seen: ok %0d, underflow %0d, overflow %0d, divide by zero %0d.",
             sb.by_status[pes_pkg::ST_OK], sb.by_status[pes_pkg::ST_UNDERFLOW],
             sb.by_status[pes_pkg::ST_OVERFLOW], sb.by_status[pes_pkg::ST_DIVZERO]);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("prefix_expression_stack_evaluator test passed");
    end else begin
      $display("prefix_expression_stack_evaluator test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still pending", sb.pending());
    $display("prefix_expression_stack_evaluator test failed");
    $finish;
  end

endmodule

/* prefix_expression_stack_evaluator.f */
rtl/core/pes_pkg.sv
rtl/core/pes_ram.sv
rtl/core/pes_div.sv
rtl/core/prefix_expression_stack_evaluator.sv
rtl/core/pes_chk.sv
verif/prefix_expression_stack_evaluator_tb.sv
